>>> rtl/tcbp_pkg.sv
package tcbp_pkg;

  localparam int BUFFER_SLOTS = 29;
  // buffer address, fill count and scan index widths
  localparam int AW = $clog2(BUFFER_SLOTS);
  localparam int FW = $clog2(BUFFER_SLOTS + 1);
  localparam int KW = $clog2(BUFFER_SLOTS + 3);

  localparam int RX_W    = 8;
  localparam int REPLY_W = 3;
  localparam int LEVEL_W = 7;
  localparam int CMP_W   = 10;

  localparam logic [RX_W-1:0] CH_TERM  = 8'h21;
  localparam logic [RX_W-1:0] CH_PCT   = 8'h25;
  localparam logic [RX_W-1:0] CH_DIG0  = 8'h30;
  localparam logic [RX_W-1:0] CH_DIG9  = 8'h39;
  localparam logic [RX_W-1:0] CH_NUL   = 8'h00;

  localparam logic [REPLY_W-1:0] R_ON         = 3'd0;
  localparam logic [REPLY_W-1:0] R_OFF        = 3'd1;
  localparam logic [REPLY_W-1:0] R_LEVEL_OK   = 3'd2;
  localparam logic [REPLY_W-1:0] R_LEVEL_ERR  = 3'd3;
  localparam logic [REPLY_W-1:0] R_ERROR      = 3'd4;
  localparam logic [REPLY_W-1:0] R_STATUS_ON  = 3'd5;
  localparam logic [REPLY_W-1:0] R_STATUS_OFF = 3'd6;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd50;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_SAT   = 7'd101;

  localparam logic [1:0] W_ON     = 2'd0;
  localparam logic [1:0] W_OFF    = 2'd1;
  localparam logic [1:0] W_STATUS = 2'd2;
  localparam logic [1:0] W_PFX    = 2'd3;

  localparam logic [KW-1:0] PFX_LEN = KW'(4);

  typedef struct packed {
    logic               on_hit;
    logic               off_hit;
    logic               status_hit;
    logic               pfx_ok;
    logic               pwm_form;
    logic [LEVEL_W-1:0] pwm_value;
  } match_res_t;

  // expected character of a keyword at a position, nul past its end
  function automatic logic [RX_W-1:0] word_char(input logic [1:0] w, input logic [KW-1:0] idx);
    logic [RX_W-1:0] c;
    c = CH_NUL;
    case (w)
      W_ON: begin
        case (idx)
          KW'(0):  c = "O";
          KW'(1):  c = "N";
          default: c = CH_NUL;
        endcase
      end
      W_OFF: begin
        case (idx)
          KW'(0):  c = "O";
          KW'(1):  c = "F";
          KW'(2):  c = "F";
          default: c = CH_NUL;
        endcase
      end
      W_STATUS: begin
        case (idx)
          KW'(0):  c = "S";
          KW'(1):  c = "t";
          KW'(2):  c = "a";
          KW'(3):  c = "t";
          KW'(4):  c = "u";
          KW'(5):  c = "s";
          default: c = CH_NUL;
        endcase
      end
      W_PFX: begin
        case (idx)
          KW'(0):  c = "P";
          KW'(1):  c = "W";
          KW'(2):  c = "M";
          KW'(3):  c = ":";
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/tcbp_if.sv
interface tcbp_in_if;
  logic                      valid;
  logic                      ready;
  logic [tcbp_pkg::RX_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tcbp_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcbp_pkg::REPLY_W-1:0] reply;
  logic                         lamp_on;
  logic [tcbp_pkg::LEVEL_W-1:0] brightness;
  logic [tcbp_pkg::CMP_W-1:0]   compare_value;

  modport source (output valid, output reply, output lamp_on, output brightness,
                  output compare_value, input ready);
  modport sink (input valid, input reply, input lamp_on, input brightness,
                input compare_value, output ready);
endinterface

>>> rtl/text_command_brightness_parser.sv
// channel   dir  port     payload
// input     in   in_ch    rx_byte[7:0]
// result    out  out_ch   reply[2:0] lamp_on brightness[6:0] compare_value[9:0]
//
// a plain byte is written to the text buffer and input stays ready for the next byte
// a '!' reads the buffer back one byte a cycle, paced by the single read port of the
//   buffer memory
// the result sits in an output register; bytes are taken while it waits, a second '!' stalls
//   before its result is loaded until the first has been taken
// reset (rst_n, synchronous, low): lamp off, brightness 50, buffer empty
module text_command_brightness_parser import tcbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tcbp_in_if.sink           in_ch,
  tcbp_out_if.source        out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [RX_W-1:0]    mem [BUFFER_SLOTS];
  logic [RX_W-1:0]    q_r;

  logic [1:0]         state_r;
  logic [FW-1:0]      fill_r;
  logic [KW-1:0]      iss_r;
  logic [KW-1:0]      ev_idx_r;
  logic               ev_v_r;
  logic               ev_in_r;
  logic [LEVEL_W-1:0] level_r;
  logic               lamp_r;
  logic [REPLY_W-1:0] reply_r;

  logic               out_valid_r;
  logic [REPLY_W-1:0] out_reply_r;
  logic               out_lamp_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [CMP_W-1:0]   out_cmp_r;

  logic               in_fire;
  logic               is_term;
  logic               wr_en;
  logic               rd_en;
  logic [RX_W-1:0]    ev_byte;
  logic               scan_done;
  logic               out_free;
  logic               out_load;
  logic [CMP_W-1:0]   cmp_val;
  match_res_t         mres;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_term     = (in_ch.rx_byte == CH_TERM);
  assign wr_en       = in_fire && !is_term && (fill_r < FW'(BUFFER_SLOTS));
  assign rd_en       = (state_r == ST_SCAN) && (iss_r < KW'(fill_r));
  // past the fill count the text reads as nul
  assign ev_byte     = ev_in_r ? q_r : CH_NUL;
  assign scan_done   = ev_v_r && (ev_byte == CH_NUL);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = (state_r == ST_OUT) && out_free;
  assign cmp_val     = lamp_r ? ({level_r, 3'b000} + {2'b00, level_r, 1'b0}) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= in_ch.rx_byte;
    end
    if (rd_en) begin
      q_r <= mem[iss_r[AW-1:0]];
    end
  end

  tcbp_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire && is_term),
    .step    (ev_v_r),
    .byte_in (ev_byte),
    .idx     (ev_idx_r),
    .res     (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      iss_r       <= '0;
      ev_idx_r    <= '0;
      ev_v_r      <= 1'b0;
      ev_in_r     <= 1'b0;
      level_r     <= LEVEL_RESET;
      lamp_r      <= 1'b0;
      reply_r     <= R_ERROR;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_term) begin
              iss_r   <= '0;
              ev_v_r  <= 1'b0;
              state_r <= ST_SCAN;
            end else if (fill_r < FW'(BUFFER_SLOTS)) begin
              fill_r <= fill_r + FW'(1);
            end else begin
              fill_r <= '0;
            end
          end
        end
        ST_SCAN: begin
          iss_r    <= iss_r + KW'(1);
          ev_idx_r <= iss_r;
          ev_in_r  <= rd_en;
          ev_v_r   <= !scan_done;
          if (scan_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          fill_r  <= '0;
          state_r <= ST_OUT;
          if (mres.on_hit) begin
            lamp_r  <= 1'b1;
            reply_r <= R_ON;
          end else if (mres.off_hit) begin
            lamp_r  <= 1'b0;
            reply_r <= R_OFF;
          end else if (mres.pfx_ok) begin
            if (!mres.pwm_form) begin
              reply_r <= R_ERROR;
            end else if (mres.pwm_value <= LEVEL_MAX) begin
              level_r <= mres.pwm_value;
              reply_r <= R_LEVEL_OK;
            end else begin
              reply_r <= R_LEVEL_ERR;
            end
          end else if (mres.status_hit) begin
            reply_r <= lamp_r ? R_STATUS_ON : R_STATUS_OFF;
          end else begin
            reply_r <= R_ERROR;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reply_r <= reply_r;
      out_lamp_r  <= lamp_r;
      out_level_r <= level_r;
      out_cmp_r   <= cmp_val;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.reply         = out_reply_r;
  assign out_ch.lamp_on       = out_lamp_r;
  assign out_ch.brightness    = out_level_r;
  assign out_ch.compare_value = out_cmp_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(BUFFER_SLOTS))
    else $error("fill count beyond buffer size");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_MAX)
    else $error("stored brightness above maximum");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (iss_r <= KW'(fill_r) + KW'(1)))
    else $error("scan ran past the held text");

  a_term_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_term) |=> (state_r == ST_SCAN) && (fill_r == $past(fill_r)))
    else $error("terminator did not start a scan");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result loaded outside of the output step");

endmodule

>>> rtl/tcbp_match.sv
module tcbp_match import tcbp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            step,
  input  logic [RX_W-1:0] byte_in,
  input  logic [KW-1:0]   idx,
  output match_res_t      res
);

  localparam logic [1:0] PW_DIG = 2'd0;
  localparam logic [1:0] PW_PCT = 2'd1;
  localparam logic [1:0] PW_BAD = 2'd2;

  logic               on_r, on_nxt;
  logic               off_r, off_nxt;
  logic               stat_r, stat_nxt;
  logic               pfx_r, pfx_nxt;
  logic [1:0]         pw_st_r, pw_st_nxt;
  logic [LEVEL_W-1:0] val_r, val_nxt;
  logic [10:0]        acc;
  logic               is_digit;

  assign is_digit = (byte_in >= CH_DIG0) && (byte_in <= CH_DIG9);
  // value * 10 + digit
  assign acc = {1'b0, val_r, 3'b000} + {3'b000, val_r, 1'b0} + {7'd0, byte_in[3:0]};

  always_comb begin
    on_nxt    = on_r;
    off_nxt   = off_r;
    stat_nxt  = stat_r;
    pfx_nxt   = pfx_r;
    pw_st_nxt = pw_st_r;
    val_nxt   = val_r;
    if (start) begin
      on_nxt    = 1'b1;
      off_nxt   = 1'b1;
      stat_nxt  = 1'b1;
      pfx_nxt   = 1'b1;
      pw_st_nxt = PW_DIG;
      val_nxt   = '0;
    end else if (step) begin
      on_nxt   = on_r && (byte_in == word_char(W_ON, idx));
      off_nxt  = off_r && (byte_in == word_char(W_OFF, idx));
      stat_nxt = stat_r && (byte_in == word_char(W_STATUS, idx));
      pfx_nxt  = pfx_r && ((idx >= PFX_LEN) || (byte_in == word_char(W_PFX, idx)));
      if ((idx >= PFX_LEN) && (byte_in != CH_NUL)) begin
        case (pw_st_r)
          PW_DIG: begin
            if (is_digit) begin
              val_nxt = (acc > {4'd0, LEVEL_SAT}) ? LEVEL_SAT : acc[LEVEL_W-1:0];
            end else if (byte_in == CH_PCT) begin
              pw_st_nxt = PW_PCT;
            end else begin
              pw_st_nxt = PW_BAD;
            end
          end
          PW_PCT:  pw_st_nxt = PW_BAD;
          default: pw_st_nxt = PW_BAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= 1'b0;
      off_r   <= 1'b0;
      stat_r  <= 1'b0;
      pfx_r   <= 1'b0;
      pw_st_r <= PW_BAD;
      val_r   <= '0;
    end else begin
      on_r    <= on_nxt;
      off_r   <= off_nxt;
      stat_r  <= stat_nxt;
      pfx_r   <= pfx_nxt;
      pw_st_r <= pw_st_nxt;
      val_r   <= val_nxt;
    end
  end

  assign res.on_hit     = on_r;
  assign res.off_hit    = off_r;
  assign res.status_hit = stat_r;
  assign res.pfx_ok     = pfx_r;
  assign res.pwm_form   = pfx_r && (pw_st_r == PW_PCT);
  assign res.pwm_value  = val_r;

endmodule

>>> verif/lamp_reply_checker.sv
`timescale 1ns / 1ps

module lamp_reply_checker import tcbp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tcbp_in_if   in_ch,
  tcbp_out_if  out_ch,
  output int   mismatches,
  output int   awaiting
);

  localparam int DRIVE_SCALE = 10;

  typedef struct packed {
    logic [REPLY_W-1:0] reply;
    logic               lamp_on;
    logic [LEVEL_W-1:0] brightness;
    logic [CMP_W-1:0]   compare_value;
  } lamp_reply_t;

  logic [RX_W-1:0]    text_buf [BUFFER_SLOTS];
  int                 held_count;
  logic [LEVEL_W-1:0] level;
  logic               lamp;
  logic [CMP_W-1:0]   drive;
  lamp_reply_t        pending_replies [$];

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // bytes past the fill count read as nul
  function automatic logic [RX_W-1:0] held_char(input int k);
    if (k < held_count && k < BUFFER_SLOTS) return text_buf[k];
    return CH_NUL;
  endfunction

  // held text up to its first nul equals the word
  function automatic bit held_text_is(input string word);
    logic [RX_W-1:0] want;
    for (int k = 0; k <= BUFFER_SLOTS; k++) begin
      want = (k < word.len()) ? RX_W'(word[k]) : CH_NUL;
      if (held_char(k) != want) return 1'b0;
      if (want == CH_NUL) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [REPLY_W-1:0] run_command();
    int k;
    int value;
    if (held_text_is("ON")) begin
      lamp  = 1'b1;
      drive = CMP_W'(level * DRIVE_SCALE);
      return R_ON;
    end
    if (held_text_is("OFF")) begin
      lamp  = 1'b0;
      drive = '0;
      return R_OFF;
    end
    if (held_char(0) == "P" && held_char(1) == "W" && held_char(2) == "M" &&
        held_char(3) == ":") begin
      k = 4;
      value = 0;
      // saturate so long digit strings stay out of range
      while (held_char(k) >= CH_DIG0 && held_char(k) <= CH_DIG9) begin
        value = value * 10 + int'(held_char(k) - CH_DIG0);
        if (value > int'(LEVEL_SAT)) value = int'(LEVEL_SAT);
        k++;
      end
      if (held_char(k) == CH_PCT && held_char(k + 1) == CH_NUL) begin
        if (value <= int'(LEVEL_MAX)) begin
          level = LEVEL_W'(value);
          if (lamp) drive = CMP_W'(level * DRIVE_SCALE);
          return R_LEVEL_OK;
        end
        return R_LEVEL_ERR;
      end
      return R_ERROR;
    end
    if (held_text_is("Status")) return lamp ? R_STATUS_ON : R_STATUS_OFF;
    return R_ERROR;
  endfunction

  function automatic void take_rx_byte(input logic [RX_W-1:0] b);
    lamp_reply_t r;
    if (b != CH_TERM) begin
      if (held_count < BUFFER_SLOTS) begin
        text_buf[held_count] = b;
        held_count++;
      end else begin
        // full buffer: drop the byte and start over
        held_count = 0;
      end
    end else begin
      r.reply         = run_command();
      held_count      = 0;
      r.lamp_on       = lamp;
      r.brightness    = level;
      r.compare_value = drive;
      pending_replies.push_back(r);
    end
  endfunction

  task automatic check_reply();
    lamp_reply_t want;
    if (pending_replies.size() == 0) begin
      report_mismatch("result with no command pending, reply", out_ch.reply, -1);
      return;
    end
    want = pending_replies.pop_front();
    if (out_ch.reply !== want.reply)
      report_mismatch("reply", out_ch.reply, want.reply);
    if (out_ch.lamp_on !== want.lamp_on)
      report_mismatch("lamp_on", out_ch.lamp_on, want.lamp_on);
    if (out_ch.brightness !== want.brightness)
      report_mismatch("brightness", out_ch.brightness, want.brightness);
    if (out_ch.compare_value !== want.compare_value)
      report_mismatch("compare_value", out_ch.compare_value, want.compare_value);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      level      = LEVEL_RESET;
      lamp       = 1'b0;
      drive      = '0;
      pending_replies.delete();
    end else begin
      // a result never belongs to a request taken at the same edge
      if (out_ch.valid && out_ch.ready) check_reply();
      if (in_ch.valid && in_ch.ready) take_rx_byte(in_ch.rx_byte);
    end
    awaiting = pending_replies.size();
  end

endmodule

>>> verif/text_command_brightness_parser_tb.sv
`timescale 1ns / 1ps

module text_command_brightness_parser_tb;
  import tcbp_pkg::*;

  localparam int RX_ITEMS     = 1050;
  localparam int DRAIN_CYCLES = 60;

  logic            clk;
  logic            rst_n;
  bit              steady;
  int              rx_sent;
  int              mismatches;
  int              awaiting;
  logic [RX_W-1:0] cmd_bytes [$];

  tcbp_in_if  in_ch ();
  tcbp_out_if out_ch ();

  text_command_brightness_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lamp_reply_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [RX_W-1:0] rand_plain();
    logic [RX_W-1:0] b;
    do b = RX_W'($urandom_range(0, 255)); while (b == CH_TERM);
    return b;
  endfunction

  function automatic logic [RX_W-1:0] rand_digit();
    return RX_W'(CH_DIG0 + $urandom_range(0, 9));
  endfunction

  function automatic string pick_keyword();
    case ($urandom_range(0, 2))
      0:       return "ON";
      1:       return "OFF";
      default: return "Status";
    endcase
  endfunction

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) cmd_bytes.push_back(RX_W'(s[k]));
  endtask

  task automatic send_byte(input logic [RX_W-1:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    rx_sent++;
  endtask

  task automatic send_command();
    cmd_bytes.push_back(CH_TERM);
    foreach (cmd_bytes[k]) send_byte(cmd_bytes[k]);
    cmd_bytes.delete();
  endtask

  task automatic send_text_command(input string s);
    add_text(s);
    send_command();
  endtask

  task automatic build_random_command();
    int n;
    int idx;
    int value;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: add_text(pick_keyword());
      5, 6, 7, 8, 18: begin
        value = ($urandom_range(0, 3) == 0) ? 100 * $urandom_range(0, 1)
                                            : $urandom_range(0, 100);
        add_text("PWM:");
        repeat ($urandom_range(0, 2)) cmd_bytes.push_back(CH_DIG0);
        add_text($sformatf("%0d%%", value));
      end
      9: begin
        // long digit strings, up to a completely full buffer
        add_text("PWM:");
        n = $urandom_range(3, BUFFER_SLOTS - 5);
        cmd_bytes.push_back(RX_W'(CH_DIG0 + $urandom_range(1, 9)));
        repeat (n - 1) cmd_bytes.push_back(rand_digit());
        cmd_bytes.push_back(CH_PCT);
      end
      10, 11: begin
        add_text("PWM:");
        repeat ($urandom_range(0, 3)) cmd_bytes.push_back(rand_digit());
        case ($urandom_range(0, 3))
          0: ;
          1: begin
            cmd_bytes.push_back(CH_PCT);
            cmd_bytes.push_back(rand_plain());
          end
          2: begin
            cmd_bytes.push_back(rand_plain());
            cmd_bytes.push_back(CH_PCT);
          end
          default: add_text("%%");
        endcase
      end
      12: begin
        // text after a nul is never looked at
        add_text(pick_keyword());
        cmd_bytes.push_back(CH_NUL);
        repeat ($urandom_range(0, 4)) cmd_bytes.push_back(rand_plain());
      end
      13, 19: begin
        add_text(($urandom_range(0, 3) == 0) ? "PWM:" : pick_keyword());
        case ($urandom_range(0, 2))
          0: begin
            idx = $urandom_range(0, cmd_bytes.size() - 1);
            cmd_bytes[idx] = cmd_bytes[idx] ^ RX_W'(1 << $urandom_range(0, 7));
            if (cmd_bytes[idx] == CH_TERM) cmd_bytes[idx] = cmd_bytes[idx] ^ 8'h40;
          end
          1: void'(cmd_bytes.pop_back());
          default: cmd_bytes.push_back(rand_plain());
        endcase
      end
      14: ;
      15: begin
        // fill or overrun the buffer with plain bytes, then maybe append a keyword
        repeat ($urandom_range(BUFFER_SLOTS, BUFFER_SLOTS + 4))
          cmd_bytes.push_back(rand_plain());
        if ($urandom_range(0, 1) == 1) add_text(pick_keyword());
      end
      default: begin
        repeat ($urandom_range(0, 8)) cmd_bytes.push_back(RX_W'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // result side: at most one stall before each result, none in steady stretches
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    steady        = 1'b0;
    rx_sent       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_text_command("");
    send_text_command("Status");
    send_text_command("PWM:0%");
    send_text_command("ON");
    send_text_command("PWM:101%");
    send_text_command("OFF");

    while (rx_sent < RX_ITEMS) begin
      if ($urandom_range(0, 15) == 0) steady = ~steady;
      build_random_command();
      send_command();
    end
    in_ch.valid <= 1'b0;

    do @(negedge clk); while (awaiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
